FILE: sv/savitzky_golay_stream_filter_defines.svh
// Assertion macros used by the filter controller.
`ifndef SAVITZKY_GOLAY_STREAM_FILTER_DEFINES_SVH
`define SAVITZKY_GOLAY_STREAM_FILTER_DEFINES_SVH
// Implication in the same cycle, disabled while in reset.
`define SGSF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sgsf assertion failed");
// Implication checked in the next cycle, disabled while in reset.
`define SGSF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sgsf assertion failed");
`endif

FILE: sv/sgsf_pkg.sv
// Types, codes and constants of the Savitzky-Golay stream filter.
package sgsf_pkg;
	localparam int MAX_HALF_WINDOW_DEF = 16;
	localparam int ROW_W = 5;
	localparam int TAP_W = 6;
	localparam int SCALE_CHUNKS = 3;

	localparam logic [2:0] CMD_LOAD_CENTER = 3'd0;
	localparam logic [2:0] CMD_LOAD_EDGE   = 3'd1;
	localparam logic [2:0] CMD_PUSH        = 3'd2;
	localparam logic [2:0] CMD_FLUSH_TRAIL = 3'd3;
	localparam logic [2:0] CMD_FLUSH_LEAD  = 3'd4;
	localparam logic [2:0] CMD_RESTART     = 3'd5;

	localparam logic [1:0] KIND_LEAD   = 2'd0;
	localparam logic [1:0] KIND_CENTER = 2'd1;
	localparam logic [1:0] KIND_TRAIL  = 2'd2;

	localparam logic CFG_HALF_WINDOW  = 1'b0;
	localparam logic CFG_OUTPUT_SCALE = 1'b1;

	typedef struct packed {
		logic [2:0]          cmd;
		logic [5:0]          tap_index;
		logic [3:0]          edge_row;
		logic signed [23:0]  weight_value;
		logic signed [15:0]  sample_value;
	} in_item_t;

	typedef struct packed {
		logic signed [23:0] filtered_value;
		logic [1:0]         output_kind;
		logic               last_of_run;
		logic [31:0]        emitted_total;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_SCALE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic             accept;
		logic             mac_clear;
		logic             mac_issue;
		logic [TAP_W-1:0] tap;
		logic [1:0]       kind;
		logic [ROW_W-1:0] row;
		logic             scale_start;
		logic             scale_issue;
		logic [1:0]       chunk;
		logic             out_load;
		logic             last;
	} ctl_t;

	typedef struct packed {
		logic full;
		logic push_full;
		logic filling;
		logic mac_busy;
		logic out_free;
	} dp_stat_t;
endpackage

FILE: sv/sgsf_dp.sv
// Datapath: sample ring, coefficient memories, multiply-accumulate, scaling and result register.
module sgsf_dp #(
	parameter int MAX_HALF_WINDOW = sgsf_pkg::MAX_HALF_WINDOW_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sgsf_pkg::in_item_t  item,
	input  logic [4:0]          n_eff,
	input  logic [23:0]         output_scale,
	input  sgsf_pkg::ctl_t      ctl,
	output sgsf_pkg::dp_stat_t  stat,
	output logic                result_valid,
	input  logic                result_stall,
	output sgsf_pkg::out_item_t result
);
	import sgsf_pkg::*;

	localparam int MAX_WINDOW = 2 * MAX_HALF_WINDOW + 1;
	localparam int EDGE_DEPTH = MAX_HALF_WINDOW * MAX_WINDOW;
	localparam int RING_AW = $clog2(MAX_WINDOW);
	localparam int EDGE_AW = $clog2(EDGE_DEPTH);

	logic signed [15:0] ring_mem [MAX_WINDOW];
	logic signed [23:0] center_mem [MAX_WINDOW];
	logic signed [23:0] edge_mem [EDGE_DEPTH];
	logic [MAX_WINDOW-1:0] ring_vld_q;

	logic [5:0]  wp_q;
	logic [5:0]  rcount_q;
	logic [31:0] count_q;

	logic [5:0] ws;
	logic [5:0] start;
	logic [6:0] rc_inc;
	logic [5:0] off;
	logic [6:0] pos_sum;
	logic [6:0] pos;
	logic [RING_AW-1:0] pos_idx;
	logic [RING_AW-1:0] start_idx;
	logic [EDGE_AW-1:0] edge_rd_addr;
	logic [EDGE_AW-1:0] edge_wr_addr;
	logic tap_ok;
	logic row_ok;
	logic is_push;
	logic is_restart;
	logic is_center_ld;
	logic is_edge_ld;

	logic signed [15:0] samp_s1;
	logic               svld_s1;
	logic signed [23:0] cen_s1;
	logic signed [23:0] edg_s1;
	logic               center_s1;
	logic               v_s1;
	logic               v_s2;
	logic signed [15:0] samp_sel;
	logic signed [23:0] coef_sel;
	logic signed [39:0] prod_s2;
	logic signed [47:0] acc_q;

	logic        neg_q;
	logic [47:0] mag_q;
	logic [71:0] sum_q;
	logic [39:0] prod_sc_s1;
	logic [1:0]  k_s1;
	logic        sv_s1;

	logic [35:0] q;
	logic [23:0] val;
	logic        result_valid_q;
	out_item_t   result_q;

	assign ws = {n_eff, 1'b1};
	assign start = (wp_q < ws) ? wp_q : '0;
	assign start_idx = start[RING_AW-1:0];
	assign rc_inc = {1'b0, rcount_q} + 7'd1;

	assign is_push      = ctl.accept && (item.cmd == CMD_PUSH);
	assign is_restart   = ctl.accept && (item.cmd == CMD_RESTART);
	assign tap_ok       = item.tap_index < TAP_W'(MAX_WINDOW);
	assign row_ok       = {1'b0, item.edge_row} < ROW_W'(MAX_HALF_WINDOW);
	assign is_center_ld = ctl.accept && (item.cmd == CMD_LOAD_CENTER) && tap_ok;
	assign is_edge_ld   = ctl.accept && (item.cmd == CMD_LOAD_EDGE) && tap_ok && row_ok;

	assign off = (ctl.kind == KIND_LEAD) ? (ws - 6'd1 - ctl.tap) : ctl.tap;
	assign pos_sum = {1'b0, start} + {1'b0, off};
	assign pos = (pos_sum >= {1'b0, ws}) ? (pos_sum - {1'b0, ws}) : pos_sum;
	assign pos_idx = pos[RING_AW-1:0];
	assign edge_rd_addr = EDGE_AW'(int'(ctl.row) * MAX_WINDOW + int'(ctl.tap));
	assign edge_wr_addr = EDGE_AW'(int'(item.edge_row) * MAX_WINDOW + int'(item.tap_index));

	assign stat.full      = rcount_q >= ws;
	assign stat.filling   = rcount_q < ws;
	assign stat.push_full = rc_inc >= {1'b0, ws};
	assign stat.mac_busy  = v_s1 || v_s2;
	assign stat.out_free  = !result_valid_q || !result_stall;

	always_ff @(posedge clk) begin
		if (is_push) begin
			ring_mem[start_idx] <= item.sample_value;
		end
		if (is_center_ld) begin
			center_mem[item.tap_index[RING_AW-1:0]] <= item.weight_value;
		end
		if (is_edge_ld) begin
			edge_mem[edge_wr_addr] <= item.weight_value;
		end
		if (ctl.mac_issue) begin
			samp_s1   <= ring_mem[pos_idx];
			svld_s1   <= ring_vld_q[pos_idx];
			cen_s1    <= center_mem[ctl.tap[RING_AW-1:0]];
			edg_s1    <= edge_mem[edge_rd_addr];
			center_s1 <= ctl.kind == KIND_CENTER;
		end
	end

	assign samp_sel = svld_s1 ? samp_s1 : '0;
	assign coef_sel = center_s1 ? cen_s1 : edg_s1;

	always_ff @(posedge clk) begin
		prod_s2 <= coef_sel * samp_sel;
		if (ctl.mac_clear) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + {{8{prod_s2[39]}}, prod_s2};
		end
		if (ctl.scale_start) begin
			neg_q <= acc_q[47];
			mag_q <= acc_q[47] ? (48'd0 - acc_q) : acc_q;
			sum_q <= 72'd1 << 35;
		end else if (sv_s1) begin
			sum_q <= sum_q + ({32'd0, prod_sc_s1} << (16 * k_s1));
		end
		if (ctl.scale_issue) begin
			prod_sc_s1 <= {24'd0, mag_q[16 * ctl.chunk +: 16]} * {16'd0, output_scale};
			k_s1       <= ctl.chunk;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			sv_s1      <= 1'b0;
			ring_vld_q <= '0;
			wp_q       <= '0;
			rcount_q   <= '0;
			count_q    <= '0;
		end else begin
			v_s1  <= ctl.mac_issue;
			v_s2  <= v_s1;
			sv_s1 <= ctl.scale_issue;
			if (is_restart) begin
				ring_vld_q <= '0;
				wp_q       <= '0;
				rcount_q   <= '0;
				count_q    <= '0;
			end else begin
				if (is_push) begin
					ring_vld_q[start_idx] <= 1'b1;
					wp_q     <= ({1'b0, start} + 7'd1 >= {1'b0, ws}) ? 6'd0 : start + 6'd1;
					rcount_q <= (rc_inc > {1'b0, ws}) ? ws : rc_inc[5:0];
				end
				if (ctl.out_load) begin
					count_q <= count_q + 32'd1;
				end
			end
		end
	end

	always_comb begin
		q = sum_q[71:36];
		if (neg_q) begin
			val = (q > 36'h800000) ? 24'h800000 : (24'd0 - q[23:0]);
		end else begin
			val = (q > 36'h7FFFFF) ? 24'h7FFFFF : q[23:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			result_q.filtered_value <= val;
			result_q.output_kind    <= ctl.kind;
			result_q.last_of_run    <= ctl.last;
			result_q.emitted_total  <= count_q + 32'd1;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;
endmodule

FILE: sv/sgsf_ctrl.sv
// Controller state machine that sequences the outputs of each transaction.
module sgsf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  logic [2:0]         item_cmd,
	input  logic [4:0]         n_eff,
	input  sgsf_pkg::dp_stat_t stat,
	output logic               item_stall,
	output sgsf_pkg::ctl_t     ctl
);
	import sgsf_pkg::*;
	`include "savitzky_golay_stream_filter_defines.svh"

	state_t st_q;
	state_t st_d;
	logic [TAP_W-1:0] i_q;
	logic [1:0]       k_q;
	logic [1:0]       kind_q;
	logic [ROW_W-1:0] row_q;
	logic             pend_q;
	logic [5:0]       ws;
	logic [ROW_W-1:0] row_top;
	logic             acc;
	logic             start_run;
	logic             last_out;

	assign ws = {n_eff, 1'b1};
	assign row_top = n_eff - 5'd1;
	assign acc = (st_q == ST_IDLE) && item_valid;
	assign start_run = acc && (((item_cmd == CMD_PUSH) && stat.push_full) ||
		(((item_cmd == CMD_FLUSH_TRAIL) || (item_cmd == CMD_FLUSH_LEAD)) && stat.full));
	assign last_out = (kind_q == KIND_CENTER) ||
		((kind_q == KIND_TRAIL) && (row_q == '0)) ||
		((kind_q == KIND_LEAD) && !pend_q && (row_q == row_top));

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE:  if (start_run) st_d = ST_MAC;
			ST_MAC:   if (i_q == ws - 6'd1) st_d = ST_DRAIN;
			ST_DRAIN: if (!stat.mac_busy) st_d = ST_SCALE;
			ST_SCALE: if (k_q == 2'(SCALE_CHUNKS)) st_d = ST_OUT;
			ST_OUT:   if (stat.out_free) st_d = last_out ? ST_IDLE : ST_MAC;
			default:  st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		item_stall      = st_q != ST_IDLE;
		ctl.accept      = acc;
		ctl.mac_issue   = st_q == ST_MAC;
		ctl.mac_clear   = (st_q == ST_MAC) && (i_q == '0);
		ctl.tap         = i_q;
		ctl.kind        = kind_q;
		ctl.row         = row_q;
		ctl.scale_start = (st_q == ST_DRAIN) && !stat.mac_busy;
		ctl.scale_issue = (st_q == ST_SCALE) && (k_q != 2'(SCALE_CHUNKS));
		ctl.chunk       = k_q;
		ctl.out_load    = (st_q == ST_OUT) && stat.out_free;
		ctl.last        = last_out;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			i_q    <= '0;
			k_q    <= '0;
			kind_q <= KIND_CENTER;
			row_q  <= '0;
			pend_q <= 1'b0;
		end else begin
			st_q <= st_d;
			i_q  <= (st_q == ST_MAC) ? i_q + 6'd1 : '0;
			k_q  <= (st_q == ST_SCALE) ? k_q + 2'd1 : '0;
			if (start_run) begin
				if (item_cmd == CMD_PUSH) begin
					kind_q <= stat.filling ? KIND_LEAD : KIND_CENTER;
					pend_q <= stat.filling;
					row_q  <= '0;
				end else if (item_cmd == CMD_FLUSH_TRAIL) begin
					kind_q <= KIND_TRAIL;
					pend_q <= 1'b0;
					row_q  <= row_top;
				end else begin
					kind_q <= KIND_LEAD;
					pend_q <= 1'b0;
					row_q  <= '0;
				end
			end else if (ctl.out_load && !last_out) begin
				if (kind_q == KIND_TRAIL) begin
					row_q <= row_q - 5'd1;
				end else if (row_q == row_top) begin
					kind_q <= KIND_CENTER;
					pend_q <= 1'b0;
				end else begin
					row_q <= row_q + 5'd1;
				end
			end
		end
	end

	`SGSF_ASSERT_IMP(a_tap_in_window, clk, arst_n, st_q == ST_MAC, i_q < ws)
	`SGSF_ASSERT_NXT(a_last_to_idle, clk, arst_n, ctl.out_load && last_out, st_q == ST_IDLE)
	`SGSF_ASSERT_IMP(a_one_phase, clk, arst_n, 1'b1, $onehot0({ctl.mac_issue, ctl.scale_issue, ctl.out_load}))
endmodule

FILE: sv/savitzky_golay_stream_filter.sv
// Top level of the Savitzky-Golay stream filter: configuration registers, controller and datapath.
// Usage: transactions enter on item/item_valid/item_stall and carry a command:
// coefficient loads, sample pushes, trailing or leading flushes and restart.
// Results leave on result/result_valid/result_stall, one transaction per result.
// Configuration writes (cfg_we, cfg_index, cfg_data) belong in idle periods only.
// Loads, restart and pushes that leave the window unfilled produce no results and leave item_stall low.
// Each result (n = effective half window) runs one tap per cycle
// through a single shared multiply-accumulate, then three partial products of
// the output scaling. A push that fills the window gives n+1 results, a flush n.
// item_stall is high while a transaction's results are being computed; the
// result register lets the next result or transaction start while the
// receiver stalls, and a result computed during a stall waits until the
// register is free. Reset clears the stream counts and sample valid bits and
// sets the half-window register to 2 and output_scale to 1.0; coefficient
// memories are undefined until loaded.
module savitzky_golay_stream_filter #(
	parameter int MAX_HALF_WINDOW = sgsf_pkg::MAX_HALF_WINDOW_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  sgsf_pkg::in_item_t  item,
	output logic                result_valid,
	input  logic                result_stall,
	output sgsf_pkg::out_item_t result,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [23:0]         cfg_data
);
	import sgsf_pkg::*;

	logic [4:0]  win_half_q;
	logic [23:0] output_scale_q;
	logic [4:0]  n_eff;
	ctl_t        ctl;
	dp_stat_t    stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_half_q     <= 5'd2;
			output_scale_q <= 24'd65536;
		end else if (cfg_we) begin
			if (cfg_index == CFG_HALF_WINDOW) begin
				win_half_q <= cfg_data[4:0];
			end else begin
				output_scale_q <= cfg_data;
			end
		end
	end

	always_comb begin
		if (win_half_q == '0) begin
			n_eff = 5'd1;
		end else if (win_half_q > 5'(MAX_HALF_WINDOW)) begin
			n_eff = 5'(MAX_HALF_WINDOW);
		end else begin
			n_eff = win_half_q;
		end
	end

	sgsf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_cmd   (item.cmd),
		.n_eff      (n_eff),
		.stat       (stat),
		.item_stall (item_stall),
		.ctl        (ctl)
	);

	sgsf_dp #(
		.MAX_HALF_WINDOW (MAX_HALF_WINDOW)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.n_eff        (n_eff),
		.output_scale (output_scale_q),
		.ctl          (ctl),
		.stat         (stat),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);
endmodule

FILE: test/savitzky_golay_stream_filter_tb.sv
// Self-checking testbench of the Savitzky-Golay stream filter with its own bit-exact predictor.
module savitzky_golay_stream_filter_tb;
	import sgsf_pkg::*;

	localparam int NMAX = 16;
	localparam int WMAX = 2 * NMAX + 1;
	localparam int LOAD_N = 5;
	localparam int LOAD_W = 2 * LOAD_N + 1;
	localparam int WATCHDOG_LIMIT = 6000;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	in_item_t item;
	logic result_valid;
	logic result_stall;
	out_item_t result;
	logic cfg_we;
	logic cfg_index;
	logic [23:0] cfg_data;

	savitzky_golay_stream_filter dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	in_item_t pending_items[$];
	out_item_t expected_results[$];
	int send_idle_pct;
	int recv_stall_pct;
	int mismatches;
	int quiet_cycles;

	int center_w[WMAX];
	int edge_w[NMAX][WMAX];
	int ring[WMAX];
	int wr_ptr;
	int fill_count;
	logic [31:0] total_out;
	logic [4:0] half_reg;
	logic [23:0] scale_reg;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic int eff_half();
		if (half_reg < 1) return 1;
		if (half_reg > NMAX) return NMAX;
		return half_reg;
	endfunction

	function automatic logic [23:0] scale_and_saturate(longint acc);
		logic [127:0] mag;
		logic [127:0] q;
		mag = (acc < 0) ? 128'(-acc) : 128'(acc);
		q = (mag * 128'(scale_reg) + (128'd1 << 35)) >> 36;
		if (acc < 0) begin
			if (q > 128'h800000) q = 128'h800000;
			return 24'(-q);
		end
		if (q > 128'h7FFFFF) q = 128'h7FFFFF;
		return q[23:0];
	endfunction

	function automatic void add_output(logic [1:0] kind, int row, bit last);
		int ws;
		int start;
		int pos;
		int w;
		longint acc;
		out_item_t r;
		ws = 2 * eff_half() + 1;
		start = (wr_ptr < ws) ? wr_ptr : 0;
		acc = 0;
		for (int i = 0; i < ws; i++) begin
			pos = (kind == KIND_LEAD) ? start + ws - 1 - i : start + i;
			if (pos >= ws) pos -= ws;
			w = (kind == KIND_CENTER) ? center_w[i] : edge_w[row][i];
			acc += longint'(w) * longint'(ring[pos]);
		end
		total_out = total_out + 1;
		r.filtered_value = scale_and_saturate(acc);
		r.output_kind = kind;
		r.last_of_run = last;
		r.emitted_total = total_out;
		expected_results.push_back(r);
	endfunction

	function automatic void clear_stream();
		wr_ptr = 0;
		fill_count = 0;
		total_out = 0;
		for (int i = 0; i < WMAX; i++) ring[i] = 0;
	endfunction

	function automatic void predict_transaction(in_item_t t);
		int n;
		int ws;
		int start;
		bit filling;
		n = eff_half();
		ws = 2 * n + 1;
		case (t.cmd)
			CMD_LOAD_CENTER: begin
				if (t.tap_index < WMAX) center_w[t.tap_index] = t.weight_value;
			end
			CMD_LOAD_EDGE: begin
				if (t.tap_index < WMAX && t.edge_row < NMAX)
					edge_w[t.edge_row][t.tap_index] = t.weight_value;
			end
			CMD_PUSH: begin
				filling = fill_count < ws;
				start = (wr_ptr < ws) ? wr_ptr : 0;
				ring[start] = t.sample_value;
				wr_ptr = (start + 1 >= ws) ? 0 : start + 1;
				fill_count = (fill_count + 1 > ws) ? ws : fill_count + 1;
				if (fill_count >= ws) begin
					if (filling)
						for (int i = 0; i < n; i++) add_output(KIND_LEAD, i, 1'b0);
					add_output(KIND_CENTER, 0, 1'b1);
				end
			end
			CMD_FLUSH_TRAIL: begin
				if (fill_count >= ws)
					for (int i = 0; i < n; i++) add_output(KIND_TRAIL, n - 1 - i, i == n - 1);
			end
			CMD_FLUSH_LEAD: begin
				if (fill_count >= ws)
					for (int i = 0; i < n; i++) add_output(KIND_LEAD, i, i == n - 1);
			end
			CMD_RESTART: begin
				clear_stream();
			end
			default: begin
			end
		endcase
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && !item_stall) predict_transaction(item);
			if (!item_valid || !item_stall) begin
				if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					item <= pending_items.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		out_item_t exp_r;
		result_stall <= ($urandom_range(99) < recv_stall_pct);
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result transaction: %p", result);
				mismatches++;
			end else begin
				exp_r = expected_results.pop_front();
				if (result.filtered_value !== exp_r.filtered_value) begin
					$error("filtered_value expected %0d actual %0d",
						exp_r.filtered_value, result.filtered_value);
					mismatches++;
				end
				if (result.output_kind !== exp_r.output_kind) begin
					$error("output_kind expected %0d actual %0d",
						exp_r.output_kind, result.output_kind);
					mismatches++;
				end
				if (result.last_of_run !== exp_r.last_of_run) begin
					$error("last_of_run expected %0d actual %0d",
						exp_r.last_of_run, result.last_of_run);
					mismatches++;
				end
				if (result.emitted_total !== exp_r.emitted_total) begin
					$error("emitted_total expected %0d actual %0d",
						exp_r.emitted_total, result.emitted_total);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic in_item_t make_item(logic [2:0] cmd);
		in_item_t t;
		t.cmd = cmd;
		t.tap_index = 6'($urandom);
		t.edge_row = 4'($urandom);
		t.weight_value = 24'($urandom);
		t.sample_value = 16'($urandom);
		if ($urandom_range(9) == 0) t.sample_value = $urandom_range(1) ? 16'h7FFF : 16'h8000;
		if ($urandom_range(9) == 0) t.weight_value = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
		return t;
	endfunction

	function automatic in_item_t random_item();
		int r;
		in_item_t t;
		r = $urandom_range(99);
		if (r < 70) t = make_item(CMD_PUSH);
		else if (r < 79) t = make_item(CMD_FLUSH_TRAIL);
		else if (r < 87) t = make_item(CMD_FLUSH_LEAD);
		else if (r < 92) t = make_item(CMD_LOAD_CENTER);
		else if (r < 96) t = make_item(CMD_LOAD_EDGE);
		else if (r < 98) t = make_item(CMD_RESTART);
		else t = make_item($urandom_range(1) ? 3'd6 : 3'd7);
		return t;
	endfunction

	task automatic wait_idle();
		while (pending_items.size() > 0 || item_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_config(logic [4:0] hw, logic [23:0] sc);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_HALF_WINDOW;
		cfg_data <= {19'd0, hw};
		half_reg = hw;
		@(posedge clk);
		cfg_index <= CFG_OUTPUT_SCALE;
		cfg_data <= sc;
		scale_reg = sc;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		in_item_t t;
		logic [4:0] phase_hw[6];
		logic [23:0] phase_scale[6];
		int phase_send[6];
		int phase_recv[6];
		phase_hw = '{5'd1, 5'd5, 5'd0, 5'd4, 5'd3, 5'd2};
		phase_scale = '{24'hFFFFFF, 24'd0, 24'd12345, 24'd65536, 24'd200000, 24'd30000};
		phase_send = '{67, 0, 30, 0, 67, 0};
		phase_recv = '{0, 67, 30, 0, 67, 0};
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_HALF_WINDOW;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		mismatches = 0;
		quiet_cycles = 0;
		half_reg = 5'd2;
		scale_reg = 24'd65536;
		clear_stream();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Coefficients are loaded for every half window that produces results here.
		for (int i = 0; i < LOAD_W; i++) begin
			t = make_item(CMD_LOAD_CENTER);
			t.tap_index = 6'(i);
			pending_items.push_back(t);
		end
		for (int r = 0; r < LOAD_N; r++)
			for (int i = 0; i < LOAD_W; i++) begin
				t = make_item(CMD_LOAD_EDGE);
				t.edge_row = 4'(r);
				t.tap_index = 6'(i);
				pending_items.push_back(t);
			end
		wait_idle();

		t = make_item(CMD_FLUSH_TRAIL);
		pending_items.push_back(t);
		t = make_item(CMD_FLUSH_LEAD);
		pending_items.push_back(t);
		for (int i = 0; i < 6; i++) begin
			t = make_item(CMD_PUSH);
			t.sample_value = i[0] ? 16'h8000 : 16'h7FFF;
			pending_items.push_back(t);
		end
		pending_items.push_back(make_item(CMD_FLUSH_TRAIL));
		pending_items.push_back(make_item(CMD_FLUSH_LEAD));
		pending_items.push_back(make_item(3'd6));
		pending_items.push_back(make_item(3'd7));
		t = make_item(CMD_LOAD_CENTER);
		t.tap_index = 6'd33;
		pending_items.push_back(t);
		t = make_item(CMD_LOAD_EDGE);
		t.tap_index = 6'd63;
		pending_items.push_back(t);
		t = make_item(CMD_LOAD_CENTER);
		t.tap_index = 6'd2;
		t.weight_value = 24'h7FFFFF;
		pending_items.push_back(t);
		t = make_item(CMD_LOAD_EDGE);
		t.tap_index = 6'd0;
		t.edge_row = 4'd15;
		t.weight_value = 24'h800000;
		pending_items.push_back(t);
		pending_items.push_back(make_item(CMD_PUSH));
		pending_items.push_back(make_item(CMD_RESTART));
		pending_items.push_back(make_item(CMD_FLUSH_TRAIL));
		for (int i = 0; i < 5; i++) pending_items.push_back(make_item(CMD_PUSH));
		wait_idle();

		// The widest window is never filled; the next phase shrinks the window under it.
		write_config(5'd31, 24'd65536);
		pending_items.push_back(make_item(CMD_RESTART));
		for (int i = 0; i < 12; i++) pending_items.push_back(make_item(CMD_PUSH));
		pending_items.push_back(make_item(CMD_FLUSH_TRAIL));
		pending_items.push_back(make_item(CMD_FLUSH_LEAD));
		wait_idle();

		for (int p = 0; p < 6; p++) begin
			write_config(phase_hw[p], phase_scale[p]);
			send_idle_pct = phase_send[p];
			recv_stall_pct = phase_recv[p];
			for (int i = 0; i < 30; i++) pending_items.push_back(random_item());
			wait_idle();
		end

		if (expected_results.size() != 0) begin
			$error("%0d expected results never arrived", expected_results.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
